// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked, with async reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/lcdc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdc_pkg
// Constants, command decode and shared types of the LCD display RAM block.
// ----------------------------------------------------------------------------
package lcdc_pkg;

	localparam int RAM_BYTES = 2048;
	localparam int RAM_AW    = $clog2(RAM_BYTES);
	localparam int ADDR_W    = 12;

	localparam logic [7:0] ROW_PITCH = 8'hA6;
	localparam logic [7:0] COL_LIMIT = 8'hA6;
	localparam logic [7:0] STAT_OFF  = 8'h20;

	typedef logic [3:0] act_t;

	localparam act_t ACT_NOP       = 4'd0;
	localparam act_t ACT_WRITE     = 4'd1;
	localparam act_t ACT_READ      = 4'd2;
	localparam act_t ACT_RMW_END   = 4'd3;
	localparam act_t ACT_RESET     = 4'd4;
	localparam act_t ACT_RMW_BEGIN = 4'd5;
	localparam act_t ACT_PAGE      = 4'd6;
	localparam act_t ACT_ONOFF     = 4'd7;
	localparam act_t ACT_CONTRAST  = 4'd8;
	localparam act_t ACT_START     = 4'd9;
	localparam act_t ACT_COL_HI    = 4'd10;
	localparam act_t ACT_COL_LO    = 4'd11;
	localparam act_t ACT_STATUS    = 4'd12;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

	typedef struct packed {
		logic       rd_ram;
		logic [7:0] read_data;
		logic       display_changed;
		logic       display_on;
		logic [5:0] start_line;
		logic [4:0] contrast;
	} rsp_t;

	function automatic logic hit(input logic [10:0] w, input logic [10:0] mask);
		return (w & mask) == mask;
	endfunction

	// priority chain, first match wins
	function automatic act_t decode(input logic [10:0] w);
		act_t a;
		a = ACT_NOP;
		if (hit(w, 11'h600))      a = ACT_WRITE;
		else if (hit(w, 11'h500)) a = ACT_READ;
		else if (hit(w, 11'h2EE)) a = ACT_RMW_END;
		else if (hit(w, 11'h2E2)) a = ACT_RESET;
		else if (hit(w, 11'h2E0)) a = ACT_RMW_BEGIN;
		else if (hit(w, 11'h2C0)) a = ACT_NOP;
		else if (hit(w, 11'h2B0)) a = ACT_PAGE;
		else if (hit(w, 11'h2AE)) a = ACT_ONOFF;
		else if (hit(w, 11'h2AA)) a = ACT_NOP;
		else if (hit(w, 11'h2A8)) a = ACT_NOP;
		else if (hit(w, 11'h2A6)) a = ACT_NOP;
		else if (hit(w, 11'h2A4)) a = ACT_NOP;
		else if (hit(w, 11'h280)) a = ACT_CONTRAST;
		else if (hit(w, 11'h240)) a = ACT_START;
		else if (hit(w, 11'h230)) a = ACT_NOP;
		else if (hit(w, 11'h224)) a = ACT_NOP;
		else if (hit(w, 11'h220)) a = ACT_NOP;
		else if (hit(w, 11'h210)) a = ACT_COL_HI;
		else if (hit(w, 11'h200)) a = ACT_COL_LO;
		else if (hit(w, 11'h100)) a = ACT_STATUS;
		return a;
	endfunction

endpackage

// ===== rtl/lcdc_if.sv =====
// ----------------------------------------------------------------------------
// lcdc_cmd_if / lcdc_rsp_if
// Valid/ready channels for host accesses and their results.
// ----------------------------------------------------------------------------
interface lcdc_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] data;

	modport source (output valid, output func, output data, input ready);
	modport sink (input valid, input func, input data, output ready);
endinterface

interface lcdc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       display_changed;
	logic       display_on;
	logic [5:0] start_line;
	logic [4:0] contrast;

	modport source (output valid, output read_data, output display_changed,
		output display_on, output start_line, output contrast, input ready);
	modport sink (input valid, input read_data, input display_changed,
		input display_on, input start_line, input contrast, output ready);
endinterface

// ===== rtl/lcdc_ram.sv =====
// ----------------------------------------------------------------------------
// lcdc_ram
// Display RAM, one write and one registered read port, cleared after reset.
// ----------------------------------------------------------------------------
module lcdc_ram (
	input  logic                clk,
	input  logic                arst_n,
	input  lcdc_pkg::ram_req_t  req,
	output logic                busy,
	output logic [7:0]          rdata
);

	logic [7:0]                  mem [lcdc_pkg::RAM_BYTES];
	logic [lcdc_pkg::RAM_AW-1:0] clr_q;
	logic                        clearing_q;

	assign busy = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == lcdc_pkg::RAM_AW'(lcdc_pkg::RAM_BYTES - 1))
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= 8'h00;
		end else if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re)
			rdata <= mem[req.addr];
	end

endmodule

// ===== rtl/lcdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcdc_ctrl
// Command decode, addressing and display registers, RAM requests.
// ----------------------------------------------------------------------------
module lcdc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [2:0]         func,
	input  logic [7:0]         data,
	output lcdc_pkg::ram_req_t ram_req,
	output lcdc_pkg::rsp_t     rsp_s1
);

	logic [7:0] column_q;
	logic [3:0] page_q;
	logic [5:0] start_q;
	logic       on_q;
	logic       rmw_q;
	logic [4:0] contrast_q;

	logic [7:0] column_d;
	logic [3:0] page_d;
	logic [5:0] start_d;
	logic       on_d;
	logic       rmw_d;
	logic [4:0] contrast_d;

	lcdc_pkg::act_t            act;
	logic [lcdc_pkg::ADDR_W-1:0] addr;
	logic                      in_range;
	logic                      step;
	logic [8:0]                col_inc;
	logic [7:0]                col_adv;
	logic                      chg;
	logic [7:0]                rd;
	lcdc_pkg::rsp_t            rsp_d;

	always_comb begin
		act      = lcdc_pkg::decode({func, data});
		addr     = lcdc_pkg::ADDR_W'(column_q)
			+ lcdc_pkg::ADDR_W'(page_q) * lcdc_pkg::ADDR_W'(lcdc_pkg::ROW_PITCH);
		in_range = {1'b0, addr} < (lcdc_pkg::ADDR_W + 1)'(lcdc_pkg::RAM_BYTES);
		step     = (act == lcdc_pkg::ACT_WRITE) ? rmw_q : !rmw_q;
		col_inc  = {1'b0, column_q} + {8'd0, step};
		col_adv  = (col_inc > {1'b0, lcdc_pkg::COL_LIMIT}) ? lcdc_pkg::COL_LIMIT
			: col_inc[7:0];

		column_d   = column_q;
		page_d     = page_q;
		start_d    = start_q;
		on_d       = on_q;
		rmw_d      = rmw_q;
		contrast_d = contrast_q;
		chg        = 1'b0;
		rd         = 8'h00;

		case (act)
			lcdc_pkg::ACT_WRITE: begin
				column_d = col_adv;
				chg      = 1'b1;
			end
			lcdc_pkg::ACT_READ: begin
				column_d = col_adv;
			end
			lcdc_pkg::ACT_RMW_END: begin
				rmw_d = 1'b0;
			end
			lcdc_pkg::ACT_RMW_BEGIN: begin
				rmw_d = 1'b1;
			end
			lcdc_pkg::ACT_RESET: begin
				start_d  = 6'd0;
				column_d = 8'd0;
				page_d   = 4'd0;
			end
			lcdc_pkg::ACT_PAGE: begin
				page_d = data[3:0];
				chg    = data[3:0] != page_q;
			end
			lcdc_pkg::ACT_ONOFF: begin
				on_d = data[0];
				chg  = data[0] != on_q;
			end
			lcdc_pkg::ACT_CONTRAST: begin
				contrast_d = data[4:0];
			end
			lcdc_pkg::ACT_START: begin
				start_d = data[5:0];
				chg     = data[5:0] != start_q;
			end
			lcdc_pkg::ACT_COL_HI: begin
				column_d = {data[3:0], column_q[3:0]};
				chg      = data[3:0] != column_q[7:4];
			end
			lcdc_pkg::ACT_COL_LO: begin
				column_d = {column_q[7:4], data[3:0]};
				chg      = data[3:0] != column_q[3:0];
			end
			lcdc_pkg::ACT_STATUS: begin
				rd = on_q ? 8'h00 : lcdc_pkg::STAT_OFF;
			end
			default: begin
			end
		endcase

		ram_req.we    = accept && (act == lcdc_pkg::ACT_WRITE) && in_range;
		ram_req.re    = accept && (act == lcdc_pkg::ACT_READ) && in_range;
		ram_req.addr  = addr[lcdc_pkg::RAM_AW-1:0];
		ram_req.wdata = data;

		rsp_d.rd_ram          = (act == lcdc_pkg::ACT_READ) && in_range;
		rsp_d.read_data       = rd;
		rsp_d.display_changed = chg;
		rsp_d.display_on      = on_d;
		rsp_d.start_line      = start_d;
		rsp_d.contrast        = contrast_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= 8'd0;
			page_q     <= 4'd0;
			start_q    <= 6'd0;
			on_q       <= 1'b0;
			rmw_q      <= 1'b1;
			contrast_q <= 5'd15;
		end else if (accept) begin
			column_q   <= column_d;
			page_q     <= page_d;
			start_q    <= start_d;
			on_q       <= on_d;
			rmw_q      <= rmw_d;
			contrast_q <= contrast_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rsp_s1 <= rsp_d;
	end

endmodule

// ===== rtl/lcd_controller_display_ram.sv =====
// ----------------------------------------------------------------------------
// lcd_controller_display_ram
// Graphic LCD controller: command decoder over a cleared display RAM.
// ----------------------------------------------------------------------------
// Path: ctrl stage and RAM read register, then the output register.
// Throughput: one item per cycle while rsp is not stalled; the RAM takes
// at most one access per item. Reset: registers clear at once; then a RAM
// clear sweep, one byte per cycle, with cmd.ready low until it ends.
module lcd_controller_display_ram (
	input  logic       clk,
	input  logic       arst_n,
	lcdc_cmd_if.sink   cmd,
	lcdc_rsp_if.source rsp
);

	lcdc_pkg::ram_req_t ram_req;
	lcdc_pkg::rsp_t     rsp_s1;
	logic               ram_busy;
	logic [7:0]         ram_rdata;
	logic               valid_s1;
	logic               adv_s1;
	logic               accept;
	logic               out_valid_q;
	lcdc_pkg::rsp_t     out_d;
	lcdc_pkg::rsp_t     out_q;

	assign adv_s1    = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !ram_busy && (!valid_s1 || adv_s1);
	assign accept    = cmd.valid && cmd.ready;

	lcdc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.func    (cmd.func),
		.data    (cmd.data),
		.ram_req (ram_req),
		.rsp_s1  (rsp_s1)
	);

	lcdc_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.busy   (ram_busy),
		.rdata  (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_d           = rsp_s1;
		out_d.read_data = rsp_s1.rd_ram ? ram_rdata : rsp_s1.read_data;
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			out_q <= out_d;
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.read_data       = out_q.read_data;
	assign rsp.display_changed = out_q.display_changed;
	assign rsp.display_on      = out_q.display_on;
	assign rsp.start_line      = out_q.start_line;
	assign rsp.contrast        = out_q.contrast;

endmodule

// ===== rtl/lcdc_checker.sv =====
// ----------------------------------------------------------------------------
// lcdc_checker
// Port-level checks of the LCD display RAM block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_data,
	input logic       rsp_display_on
);

	logic [2:0] pend_q;
	logic       cmd_acc;
	logic       rsp_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'd0, cmd_acc} - {2'd0, rsp_acc};
		end
	end

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_read_data) && $stable(rsp_display_on))
	`ASSERT_IMPL(a_no_orphan, clk, arst_n, rsp_valid, pend_q != 3'd0)
	`ASSERT_IMPL(a_depth, clk, arst_n, 1'b1, pend_q <= 3'd2)

endmodule

bind lcd_controller_display_ram lcdc_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_data  (rsp.read_data),
	.rsp_display_on (rsp.display_on)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for lcd_controller_display_ram. Host accesses go in on the cmd
// channel; a shadow of the controller state predicts each result, which is
// checked field by field as it leaves on the rsp channel. A short directed
// run is followed by random cursor/RAM bursts, control commands and noise,
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STALL_LIMIT  = 10000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CALM_ITEMS   = 150;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_AFTER   = 600;
	localparam int CHAIN_LEN    = 21;

	localparam logic [2:0] FN_IDLE_LO  = 3'd0;
	localparam logic [2:0] FN_STATUS   = 3'd1;
	localparam logic [2:0] FN_CTRL     = 3'd2;
	localparam logic [2:0] FN_CTRL_ST  = 3'd3;
	localparam logic [2:0] FN_IDLE_HI  = 3'd4;
	localparam logic [2:0] FN_READ     = 3'd5;
	localparam logic [2:0] FN_WRITE    = 3'd6;
	localparam logic [2:0] FN_WRITE_ST = 3'd7;

	localparam logic [7:0] OP_RMW_END   = 8'hEE;
	localparam logic [7:0] OP_RESET     = 8'hE2;
	localparam logic [7:0] OP_RMW_BEGIN = 8'hE0;
	localparam logic [7:0] OP_NOP       = 8'hC0;
	localparam logic [7:0] OP_PAGE      = 8'hB0;
	localparam logic [7:0] OP_ONOFF     = 8'hAE;
	localparam logic [7:0] OP_NOP_A4    = 8'hA4;
	localparam logic [7:0] OP_CONTRAST  = 8'h80;
	localparam logic [7:0] OP_START     = 8'h40;
	localparam logic [7:0] OP_NOP_30    = 8'h30;
	localparam logic [7:0] OP_COL_HI    = 8'h10;
	localparam logic [7:0] OP_COL_LO    = 8'h00;

	// first mask fully present in {func, data} wins
	localparam logic [10:0] CHAIN_MASK [CHAIN_LEN] = '{
		11'h600, 11'h500, 11'h2EE, 11'h2E2, 11'h2E0, 11'h2C0, 11'h2B0,
		11'h2AE, 11'h2AA, 11'h2A8, 11'h2A6, 11'h2A4, 11'h280, 11'h2A0,
		11'h240, 11'h230, 11'h224, 11'h220, 11'h210, 11'h200, 11'h100
	};
	localparam lcdc_pkg::act_t CHAIN_ACT [CHAIN_LEN] = '{
		lcdc_pkg::ACT_WRITE, lcdc_pkg::ACT_READ, lcdc_pkg::ACT_RMW_END,
		lcdc_pkg::ACT_RESET, lcdc_pkg::ACT_RMW_BEGIN, lcdc_pkg::ACT_NOP,
		lcdc_pkg::ACT_PAGE, lcdc_pkg::ACT_ONOFF, lcdc_pkg::ACT_NOP,
		lcdc_pkg::ACT_NOP, lcdc_pkg::ACT_NOP, lcdc_pkg::ACT_NOP,
		lcdc_pkg::ACT_CONTRAST, lcdc_pkg::ACT_NOP, lcdc_pkg::ACT_START,
		lcdc_pkg::ACT_NOP, lcdc_pkg::ACT_NOP, lcdc_pkg::ACT_NOP,
		lcdc_pkg::ACT_COL_HI, lcdc_pkg::ACT_COL_LO, lcdc_pkg::ACT_STATUS
	};

	typedef struct {
		logic [7:0] read_data;
		logic       display_changed;
		logic       display_on;
		logic [5:0] start_line;
		logic [4:0] contrast;
	} lcd_result_t;

	class display_shadow;
		logic [7:0]  ram [lcdc_pkg::RAM_BYTES];
		logic [7:0]  column;
		logic [3:0]  page;
		logic [5:0]  start_line;
		logic        on_flag;
		logic        rmw;
		logic [4:0]  contrast;
		lcd_result_t bus_results [$];
		int          errors;
		int          n_checked;
		int          n_act [13];
		int          n_off_ram;
		int          n_saturate;

		function new();
			foreach (ram[i]) ram[i] = 8'h00;
			foreach (n_act[i]) n_act[i] = 0;
			column = 8'h00;
			page = 4'h0;
			start_line = 6'h00;
			on_flag = 1'b0;
			rmw = 1'b1;
			contrast = 5'd15;
			errors = 0;
			n_checked = 0;
			n_off_ram = 0;
			n_saturate = 0;
		endfunction

		function lcdc_pkg::act_t classify(logic [10:0] w);
			for (int i = 0; i < CHAIN_LEN; i++) begin
				if ((w & CHAIN_MASK[i]) == CHAIN_MASK[i]) return CHAIN_ACT[i];
			end
			return lcdc_pkg::ACT_NOP;
		endfunction

		function void settle_column(logic step);
			logic [8:0] c;
			c = {1'b0, column} + 9'(step);
			if (c > {1'b0, lcdc_pkg::COL_LIMIT}) begin
				c = {1'b0, lcdc_pkg::COL_LIMIT};
				n_saturate++;
			end
			column = c[7:0];
		endfunction

		function void note_access(logic [2:0] f, logic [7:0] d);
			lcd_result_t    r;
			lcdc_pkg::act_t a;
			logic [11:0]    addr;
			a = classify({f, d});
			n_act[a]++;
			r.read_data = 8'h00;
			r.display_changed = 1'b0;
			addr = 12'(column) + 12'(page) * 12'(lcdc_pkg::ROW_PITCH);
			case (a)
			lcdc_pkg::ACT_WRITE: begin
				if (addr < lcdc_pkg::RAM_BYTES) ram[addr[10:0]] = d;
				else n_off_ram++;
				settle_column(rmw);
				r.display_changed = 1'b1;
			end
			lcdc_pkg::ACT_READ: begin
				if (addr < lcdc_pkg::RAM_BYTES) r.read_data = ram[addr[10:0]];
				else n_off_ram++;
				settle_column(!rmw);
			end
			lcdc_pkg::ACT_RMW_END: rmw = 1'b0;
			lcdc_pkg::ACT_RMW_BEGIN: rmw = 1'b1;
			lcdc_pkg::ACT_RESET: begin
				start_line = 6'h00;
				column = 8'h00;
				page = 4'h0;
			end
			lcdc_pkg::ACT_PAGE: begin
				if (d[3:0] != page) begin
					page = d[3:0];
					r.display_changed = 1'b1;
				end
			end
			lcdc_pkg::ACT_ONOFF: begin
				if (d[0] != on_flag) begin
					on_flag = d[0];
					r.display_changed = 1'b1;
				end
			end
			lcdc_pkg::ACT_CONTRAST: contrast = d[4:0];
			lcdc_pkg::ACT_START: begin
				if (d[5:0] != start_line) begin
					start_line = d[5:0];
					r.display_changed = 1'b1;
				end
			end
			lcdc_pkg::ACT_COL_HI: begin
				if (d[3:0] != column[7:4]) begin
					column[7:4] = d[3:0];
					r.display_changed = 1'b1;
				end
			end
			lcdc_pkg::ACT_COL_LO: begin
				if (d[3:0] != column[3:0]) begin
					column[3:0] = d[3:0];
					r.display_changed = 1'b1;
				end
			end
			lcdc_pkg::ACT_STATUS: r.read_data = on_flag ? 8'h00 : lcdc_pkg::STAT_OFF;
			default: ;
			endcase
			r.display_on = on_flag;
			r.start_line = start_line;
			r.contrast = contrast;
			bus_results.push_back(r);
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(lcd_result_t got);
			lcd_result_t want;
			n_checked++;
			if (bus_results.size() == 0) begin
				$error("unexpected result: read_data 0x%0h", got.read_data);
				errors++;
				return;
			end
			want = bus_results.pop_front();
			compare("read_data", want.read_data, got.read_data);
			compare("display_changed", want.display_changed, got.display_changed);
			compare("display_on", want.display_on, got.display_on);
			compare("start_line", want.start_line, got.start_line);
			compare("contrast", want.contrast, got.contrast);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lcdc_cmd_if cmd_bus ();
	lcdc_rsp_if rsp_bus ();

	lcd_controller_display_ram u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	display_shadow shadow = new();

	bit calm = 1'b0;
	bit holding = 1'b0;
	bit long_hold_done = 1'b0;
	bit send_lively = 1'b0;
	int send_phase_left = 0;
	int items_sent = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [2:0] ctrl_func();
		return $urandom_range(0, 1) ? FN_CTRL : FN_CTRL_ST;
	endfunction

	task automatic send_access(input logic [2:0] f, input logic [7:0] d);
		cmd_bus.valid <= 1'b1;
		cmd_bus.func <= f;
		cmd_bus.data <= d;
		do @(posedge clk); while (!cmd_bus.ready);
		shadow.note_access(f, d);
		items_sent++;
		if (send_phase_left == 0) begin
			send_phase_left = $urandom_range(20, 120);
			send_lively = $urandom_range(0, 2) != 0;
		end
		send_phase_left--;
		if (!calm && !holding && send_lively && $urandom_range(0, 7) == 0) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (shadow.bus_results.size() != 0);
	endtask

	task automatic run_directed();
		send_access(FN_STATUS, 8'hFF);
		send_access(FN_IDLE_LO, 8'h00);
		send_access(FN_IDLE_HI, 8'hFF);
		send_access(FN_CTRL_ST, OP_CONTRAST | 8'h1F);
		send_access(FN_CTRL, OP_CONTRAST);
		send_access(FN_CTRL, OP_ONOFF | 8'h01);
		send_access(FN_STATUS, 8'h00);
		send_access(FN_CTRL_ST, OP_START | 8'h3F);
		send_access(FN_CTRL, OP_PAGE | 8'h0F);
		send_access(FN_CTRL, OP_COL_HI | 8'h0F);
		send_access(FN_CTRL_ST, OP_COL_LO | 8'h0F);
		// cursor past the end of RAM
		send_access(FN_WRITE_ST, 8'hFF);
		send_access(FN_READ, 8'h00);
		send_access(FN_CTRL, OP_RESET);
		send_access(FN_CTRL_ST, OP_RMW_END);
		send_access(FN_CTRL, OP_COL_HI | 8'h0A);
		send_access(FN_CTRL, OP_COL_LO | 8'h05);
		send_access(FN_WRITE, 8'h5A);
		send_access(FN_READ, 8'hFF);
		// column pinned at its limit
		send_access(FN_READ, 8'h00);
		send_access(FN_CTRL, OP_RMW_BEGIN);
		send_access(FN_WRITE, 8'hA5);
		send_access(FN_CTRL_ST, OP_NOP);
		send_access(FN_CTRL, OP_NOP_A4);
		send_access(FN_CTRL_ST, OP_NOP_30);
		send_access(FN_CTRL, OP_PAGE);
		send_access(FN_CTRL, OP_ONOFF);
	endtask

	task automatic send_control();
		logic [7:0] op;
		case ($urandom_range(0, 9))
		0: op = OP_RMW_END;
		1: op = OP_RMW_BEGIN;
		2: op = OP_RESET;
		3: op = OP_PAGE | 8'($urandom_range(0, 15));
		4: op = OP_ONOFF | 8'($urandom_range(0, 1));
		5: op = OP_CONTRAST | 8'($urandom_range(0, 31));
		6: op = OP_START | 8'($urandom_range(0, 63));
		7: op = OP_COL_HI | 8'($urandom_range(0, 15));
		8: op = OP_COL_LO | 8'($urandom_range(0, 15));
		default: op = 8'($urandom);
		endcase
		send_access(ctrl_func(), op);
	endtask

	task automatic run_random();
		int         target;
		int         kind;
		int         n;
		bit         drained_once;
		logic [7:0] col;
		logic [3:0] pg;
		target = items_sent + RANDOM_ITEMS;
		drained_once = 1'b0;
		while (items_sent < target) begin
			calm = (target - items_sent) <= CALM_ITEMS;
			if (!drained_once && (target - items_sent) < RANDOM_ITEMS / 2) begin
				drained_once = 1'b1;
				wait_drained();
			end
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				// place the cursor, write a burst, go back and read it
				pg = 4'($urandom_range(0, 15));
				col = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(150, 255))
					: 8'($urandom_range(0, 165));
				n = $urandom_range(1, 12);
				send_access(ctrl_func(), OP_PAGE | 8'(pg));
				send_access(ctrl_func(), OP_COL_HI | 8'(col[7:4]));
				send_access(ctrl_func(), OP_COL_LO | 8'(col[3:0]));
				repeat (n) send_access($urandom_range(0, 1) ? FN_WRITE : FN_WRITE_ST,
					8'($urandom));
				send_access(ctrl_func(), OP_COL_HI | 8'(col[7:4]));
				send_access(ctrl_func(), OP_COL_LO | 8'(col[3:0]));
				repeat (n) send_access(FN_READ, 8'($urandom));
			end else if (kind < 80) begin
				send_control();
			end else if (kind < 90) begin
				send_access(3'($urandom), 8'($urandom));
			end else if (kind < 95) begin
				send_access(FN_STATUS, 8'($urandom));
			end else begin
				send_access($urandom_range(0, 1) ? FN_IDLE_LO : FN_IDLE_HI, 8'($urandom));
			end
		end
	endtask

	initial begin
		int n_ctrl;
		arst_n <= 1'b0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.func <= FN_IDLE_LO;
		cmd_bus.data <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		wait_drained();
		repeat (8) @(posedge clk);
		n_ctrl = shadow.n_checked - shadow.n_act[lcdc_pkg::ACT_WRITE]
			- shadow.n_act[lcdc_pkg::ACT_READ] - shadow.n_act[lcdc_pkg::ACT_STATUS]
			- shadow.n_act[lcdc_pkg::ACT_NOP];
		$display("Run covered %0d accesses: %0d RAM writes, %0d RAM reads",
			shadow.n_checked, shadow.n_act[lcdc_pkg::ACT_WRITE],
			shadow.n_act[lcdc_pkg::ACT_READ]);
		$display("  (%0d off the RAM, %0d column clamps), %0d control commands,",
			shadow.n_off_ram, shadow.n_saturate, n_ctrl);
		$display("  %0d status reads, %0d ignored accesses; %0d errors",
			shadow.n_act[lcdc_pkg::ACT_STATUS], shadow.n_act[lcdc_pkg::ACT_NOP],
			shadow.errors);
		if (shadow.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		int          stall_left;
		int          phase_left;
		bit          lively;
		lcd_result_t got;
		stall_left = 0;
		phase_left = 0;
		lively = 1'b0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.read_data = rsp_bus.read_data;
				got.display_changed = rsp_bus.display_changed;
				got.display_on = rsp_bus.display_on;
				got.start_line = rsp_bus.start_line;
				got.contrast = rsp_bus.contrast;
				shadow.check_result(got);
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(30, 150);
				lively = $urandom_range(0, 2) != 0;
			end
			phase_left--;
			if (stall_left > 0) begin
				stall_left--;
			end else if (!long_hold_done && shadow.n_checked >= HOLD_AFTER) begin
				// long back-pressure so the block fills and stalls its input
				stall_left = LONG_HOLD;
				long_hold_done = 1'b1;
				holding = 1'b1;
			end else begin
				holding = 1'b0;
				if (!calm && lively && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 19);
			end
			rsp_bus.ready <= (stall_left == 0);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule
